/* rtl/core/ioct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_pkg
// Types, constants and codes shared by the in-order completion tracker.
// ----------------------------------------------------------------------------
package ioct_pkg;

  localparam int PARTITIONS = 16;
  localparam int WINDOW     = 32;
  localparam int SEQ_BITS   = 32;
  localparam int MAX_OUT    = 32;

  localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int OFF_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(MAX_OUT);
  localparam int PEND_W = 17;

  localparam logic [PEND_W-1:0] PEND_MAX    = {PEND_W{1'b1}};
  localparam logic [15:0]       RESET_LIMIT = 16'd10000;

  localparam logic REQ_SUBMIT   = 1'b0;
  localparam logic REQ_COMPLETE = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  typedef enum logic [2:0] {
    KIND_ACCEPTED    = 3'd0,
    KIND_BAD_PART    = 3'd1,
    KIND_BACKPRESS   = 3'd2,
    KIND_WINDOW_FULL = 3'd3,
    KIND_BYPASS      = 3'd4,
    KIND_RELEASED    = 3'd5,
    KIND_CPL_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    CMD_BYPASS   = 3'd0,
    CMD_BAD_SUB  = 3'd1,
    CMD_BAD_CPL  = 3'd2,
    CMD_SUBMIT   = 3'd3,
    CMD_COMPLETE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  partition;
    logic [31:0] seq;
    logic        success;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  out_partition;
    logic [31:0] out_seq;
    logic        out_success;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        enabled;
    logic [4:0]  partitions_in_use;
    logic [15:0] backpressure_limit;
  } cfg_t;

  typedef struct packed {
    cmd_e        op;
    logic [7:0]  partition;
    logic [31:0] seq;
    logic        success;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

/* rtl/core/in_order_completion_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_completion_tracker_unit
// Per-partition ordered completion tracker.
//
// Requests enter through a queue-style port: a transaction is taken when
// push is high and full is low. Results leave the same way: the oldest
// result is shown while empty is low and is taken when pop is high.
// Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i) and
// the user must write it only while the block is idle; nothing enforces this.
// A single-result request passes through the command queue, the engine and
// the result queue before it can be popped; one such request can be handled
// every cycle while no run is released and the result queue has room. A
// completion updates its done bits and then releases its run of finished
// sequences at one result per cycle while the result queue has room, so it
// holds the engine until the run ends; the single state port sets this.
// Reset clears all counters, pointers, done bits and the pending count and
// loads the configuration defaults. When the receiver stalls, the result
// queue fills, the engine waits, and full rises once the command queue is
// also full.
// ----------------------------------------------------------------------------
module in_order_completion_tracker_unit import ioct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  in_item_t             in_item_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  cmd_chan_t cmd;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled            <= 1'b1;
      cfg_q.partitions_in_use  <= 5'd16;
      cfg_q.backpressure_limit <= RESET_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED: cfg_q.enabled            <= cfg_wdata_i[0];
        CFG_PARTS:   cfg_q.partitions_in_use  <= cfg_wdata_i[4:0];
        CFG_LIMIT:   cfg_q.backpressure_limit <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ioct_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push      (push),
    .in_item_i (in_item_i),
    .full      (full),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  ioct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  ioct_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .item_i (res),
    .full_o (res_full),
    .empty  (empty),
    .pop    (pop),
    .item_o (out_item_o)
  );

endmodule

/* rtl/core/ioct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_front
// Accepts input transactions, classifies them and queues commands.
// ----------------------------------------------------------------------------
module ioct_front import ioct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  output cmd_chan_t cmd_o,
  input  logic      cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       bad;
  logic       wr_en;
  logic       rd_en;
  cmd_t       cmd_new;

  assign bad = (in_item_i.partition >= 8'(cfg_i.partitions_in_use)) ||
               ({1'b0, in_item_i.partition} >= 9'(PARTITIONS));

  always_comb begin
    cmd_new.partition = in_item_i.partition;
    cmd_new.seq       = in_item_i.seq;
    cmd_new.success   = in_item_i.success;
    if (in_item_i.req_type == REQ_SUBMIT) begin
      if (!cfg_i.enabled) begin
        cmd_new.op = CMD_BYPASS;
      end else if (bad) begin
        cmd_new.op = CMD_BAD_SUB;
      end else begin
        cmd_new.op = CMD_SUBMIT;
      end
    end else begin
      cmd_new.op = bad ? CMD_BAD_CPL : CMD_COMPLETE;
    end
  end

  assign full      = (cnt_q == 2'd2);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wr_en ? ~wptr_q : wptr_q;
    rptr_d = rd_en ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= cmd_new;
    end
  end

endmodule

/* rtl/core/ioct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_back
// Executes commands against the per-partition tracking state and emits result
// transactions, including release runs, one per cycle unless results back up.
// ----------------------------------------------------------------------------
module ioct_back import ioct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  cmd_chan_t cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RELEASE = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [SEQ_BITS-1:0] issue_q  [PARTITIONS];
  logic [SEQ_BITS-1:0] retire_q [PARTITIONS];
  logic [WINDOW-1:0]   done_q   [PARTITIONS];
  logic [WINDOW-1:0]   outc_q   [PARTITIONS];

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        rel_part_q, rel_part_d;

  logic [PART_W-1:0]   idx;
  logic [SEQ_BITS-1:0] iss, ret, outstanding, seq_s, off_full;
  logic [WINDOW-1:0]   dn, oc, bit_mask, done_new, outc_new;
  logic [63:0]         seq_ext, iss_ext, ret_ext;
  logic [OFF_W-1:0]    off;
  logic                win_full, cpl_ok, rel_last;
  logic                issue_inc, cpl_upd, rel_step;

  assign idx = (state_q == ST_RELEASE) ? rel_part_q[PART_W-1:0]
                                       : cmd_i.cmd.partition[PART_W-1:0];
  assign iss = issue_q[idx];
  assign ret = retire_q[idx];
  assign dn  = done_q[idx];
  assign oc  = outc_q[idx];

  assign iss_ext     = 64'(iss);
  assign ret_ext     = 64'(ret);
  assign seq_ext     = 64'(cmd_i.cmd.seq);
  assign seq_s       = seq_ext[SEQ_BITS-1:0];
  assign outstanding = iss - ret;
  assign win_full    = outstanding >= SEQ_BITS'(WINDOW);
  assign off_full    = seq_s - ret;
  assign off         = off_full[OFF_W-1:0];
  assign bit_mask    = WINDOW'(1) << off;
  assign cpl_ok      = (off_full < outstanding) && (off_full < SEQ_BITS'(WINDOW)) &&
                       !dn[off];
  assign done_new    = dn | bit_mask;
  assign outc_new    = cmd_i.cmd.success ? (oc | bit_mask) : (oc & ~bit_mask);
  assign rel_last    = !dn[1] || (cnt_q == CNT_W'(MAX_OUT - 1));

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    rel_part_d = rel_part_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    issue_inc  = 1'b0;
    cpl_upd    = 1'b0;
    rel_step   = 1'b0;
    res_o.out_kind      = KIND_ACCEPTED;
    res_o.out_partition = cmd_i.cmd.partition;
    res_o.out_seq       = '0;
    res_o.out_success   = 1'b0;
    res_o.last          = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.cmd.op)
            CMD_BYPASS: begin
              res_push_o        = 1'b1;
              res_o.out_kind    = KIND_BYPASS;
              res_o.out_success = 1'b1;
            end
            CMD_BAD_SUB: begin
              res_push_o     = 1'b1;
              res_o.out_kind = KIND_BAD_PART;
            end
            CMD_BAD_CPL: begin
              res_push_o     = 1'b1;
              res_o.out_kind = KIND_CPL_ERROR;
              res_o.out_seq  = cmd_i.cmd.seq;
            end
            CMD_SUBMIT: begin
              res_push_o = 1'b1;
              if (pend_q > PEND_W'(cfg_i.backpressure_limit)) begin
                res_o.out_kind = KIND_BACKPRESS;
              end else if (win_full) begin
                res_o.out_kind = KIND_WINDOW_FULL;
              end else begin
                res_o.out_kind = KIND_ACCEPTED;
                res_o.out_seq  = iss_ext[31:0];
                issue_inc      = 1'b1;
                if (pend_q != PEND_MAX) begin
                  pend_d = pend_q + PEND_W'(1);
                end
              end
            end
            CMD_COMPLETE: begin
              if (!cpl_ok) begin
                res_push_o     = 1'b1;
                res_o.out_kind = KIND_CPL_ERROR;
                res_o.out_seq  = cmd_i.cmd.seq;
              end else begin
                cpl_upd = 1'b1;
                if (pend_q != '0) begin
                  pend_d = pend_q - PEND_W'(1);
                end
                if (done_new[0]) begin
                  state_d    = ST_RELEASE;
                  rel_part_d = cmd_i.cmd.partition;
                  cnt_d      = '0;
                end
              end
            end
            default: begin
              res_push_o     = 1'b1;
              res_o.out_kind = KIND_CPL_ERROR;
            end
          endcase
        end
      end
      ST_RELEASE: begin
        res_o.out_kind      = KIND_RELEASED;
        res_o.out_partition = rel_part_q;
        res_o.out_seq       = ret_ext[31:0];
        res_o.out_success   = oc[0];
        res_o.last          = rel_last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          rel_step   = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
          if (rel_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_q     <= '0;
      cnt_q      <= '0;
      rel_part_q <= '0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      rel_part_q <= rel_part_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PARTITIONS; p++) begin
        issue_q[p]  <= '0;
        retire_q[p] <= '0;
        done_q[p]   <= '0;
        outc_q[p]   <= '0;
      end
    end else begin
      if (issue_inc) begin
        issue_q[idx] <= iss + SEQ_BITS'(1);
      end
      if (cpl_upd) begin
        done_q[idx] <= done_new;
        outc_q[idx] <= outc_new;
      end
      if (rel_step) begin
        done_q[idx]   <= dn >> 1;
        outc_q[idx]   <= oc >> 1;
        retire_q[idx] <= ret + SEQ_BITS'(1);
      end
    end
  end

endmodule

/* rtl/core/ioct_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_outq
// Two-entry result queue that decouples the engine from the receiver.
// ----------------------------------------------------------------------------
module ioct_outq import ioct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t item_o
);

  out_item_t  mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;
  logic       wr_en;
  logic       rd_en;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign wr_en  = push_i && !full_o;
  assign rd_en  = pop && !empty;
  assign item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_q <= ~wptr_q;
      end
      if (rd_en) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/ioct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ioct_checker
// Port-level checks of the completion tracker, attached by bind.
// ----------------------------------------------------------------------------
module ioct_checker import ioct_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  logic        run_open_q;
  logic [7:0]  run_part_q;
  logic [31:0] run_seq_q;
  logic        rejected;

  assign rejected = (out_item_o.out_kind == KIND_BAD_PART) ||
                    (out_item_o.out_kind == KIND_BACKPRESS) ||
                    (out_item_o.out_kind == KIND_WINDOW_FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      run_part_q <= '0;
      run_seq_q  <= '0;
    end else if (pop && !empty) begin
      run_open_q <= (out_item_o.out_kind == KIND_RELEASED) && !out_item_o.last;
      run_part_q <= out_item_o.out_partition;
      run_seq_q  <= out_item_o.out_seq + 32'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && run_open_q |-> (out_item_o.out_kind == KIND_RELEASED) &&
      (out_item_o.out_partition == run_part_q) && (out_item_o.out_seq == run_seq_q))
    else $error("release run broken or out of order");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rejected |-> (out_item_o.out_seq == 32'd0) && !out_item_o.out_success &&
      out_item_o.last && !run_open_q)
    else $error("malformed rejection result");

endmodule

bind in_order_completion_tracker_unit ioct_checker u_ioct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
